### src/wlps_pkg.sv
// Shared types and constants for the weighted least-use peer selector.
`timescale 1ns / 1ps
package wlps_pkg;

    localparam int USE_W      = 16;
    localparam int WEIGHT_W   = 8;
    localparam int PRIO_SHIFT = 8;
    localparam int PRIO_W     = USE_W + PRIO_SHIFT;
    localparam int ADDR_PEERS = 4;
    localparam int PIU_W      = 3;
    localparam int IVL_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_CNT_W  = $clog2(PRIO_W);

    localparam logic [CFG_IDX_W-1:0] CFG_PEERS_IN_USE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REBAL_IVL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_0     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_1     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_2     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_3     = 3'd5;

    localparam logic CMD_SELECT = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    typedef struct packed {
        logic                start;
        logic [PRIO_W-1:0]   dividend;
        logic [WEIGHT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [PRIO_W-1:0] quotient;
    } t_div_stat;

endpackage

### src/wlps_div.sv
// Shared radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wlps_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wlps_pkg::t_div_req  i_req,
    output wlps_pkg::t_div_stat o_stat
);

    logic                          r_busy;
    logic                          r_done;
    logic [wlps_pkg::PRIO_W-1:0]   r_shf;
    logic [wlps_pkg::WEIGHT_W-1:0] r_rem;
    logic [wlps_pkg::WEIGHT_W-1:0] r_div;
    logic [wlps_pkg::DIV_CNT_W-1:0] r_cnt;

    logic [wlps_pkg::WEIGHT_W:0]   w_trial;
    logic                          w_qbit;
    logic [wlps_pkg::WEIGHT_W-1:0] w_rem_next;

    always_comb begin
        w_trial    = {r_rem, r_shf[wlps_pkg::PRIO_W-1]};
        w_qbit     = (w_trial >= {1'b0, r_div});
        w_rem_next = w_qbit ? wlps_pkg::WEIGHT_W'(w_trial - {1'b0, r_div})
                            : w_trial[wlps_pkg::WEIGHT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_shf  <= i_req.dividend;
                r_div  <= i_req.divisor;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // shift the dividend out the top, quotient bits in the bottom
                r_rem <= w_rem_next;
                r_shf <= {r_shf[wlps_pkg::PRIO_W-2:0], w_qbit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == wlps_pkg::DIV_CNT_W'(wlps_pkg::PRIO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy     = r_busy;
    assign o_stat.done     = r_done;
    assign o_stat.quotient = r_shf;

endmodule

### src/weighted_least_use_peer_select_unit.sv
// Top level: peer state, scan sequencer and output register of the peer selector.
//
//  channel  dir  signals                               payload
//  s        in   i_s_tvalid o_s_tready i_s_tdata/tuser  tuser: cmd; tdata: see port
//  m        out  o_m_tvalid i_m_tready o_m_tdata        ok, chosen_peer, context_failed
//  cfg      in   i_cfg_we i_cfg_idx i_cfg_wdata         register writes, no read-back
//
//  A select visits each peer in use: a dead one is skipped in the scan; for a
//  live one the shared serial divider loads, runs 24 steps and flags done while
//  the sequencer waits. The pick and finish states then reach the output register,
//  with one all-dead retry of the scan. A failure report goes straight to finish.
//  Reset is synchronous: use counts, dead marks and the select counter clear.
//  A new beat is taken while a result waits at the output; the next result
//  holds in the sequencer until the output register frees.
`timescale 1ns / 1ps
module weighted_least_use_peer_select_unit #(
    parameter int NUM_PEERS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [0] already_failed, [2:1] failed_peer, [3] failed_peer_valid, [7:4] zero
    input  logic [7:0]                       i_s_tdata,
    // [0] cmd
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [0] ok, [2:1] chosen_peer, [3] context_failed, [7:4] zero
    output logic [7:0]                       o_m_tdata,
    input  logic                             i_cfg_we,
    input  logic [wlps_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wlps_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    localparam int NSTORE = (NUM_PEERS < wlps_pkg::ADDR_PEERS) ? NUM_PEERS
                                                               : wlps_pkg::ADDR_PEERS;
    localparam int IDX_W  = $clog2(NSTORE);
    localparam int CNT_W  = $clog2(NSTORE + 1);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_WAIT = 5'b00100,
        ST_PICK = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

    t_state r_state;

    logic [wlps_pkg::PIU_W-1:0]    r_peers_in_use;
    logic [wlps_pkg::IVL_W-1:0]    r_rebal_ivl;
    logic [wlps_pkg::WEIGHT_W-1:0] r_weight [wlps_pkg::ADDR_PEERS];

    logic [wlps_pkg::USE_W-1:0]    r_use [NSTORE];
    logic [NSTORE-1:0]             r_dead;
    logic [wlps_pkg::IVL_W-1:0]    r_sel_cnt;

    logic [CNT_W-1:0]              r_idx;
    logic                          r_best_valid;
    logic [IDX_W-1:0]              r_best_idx;
    logic [wlps_pkg::PRIO_W-1:0]   r_best_prio;
    logic                          r_failed;
    logic                          r_ok;

    logic                          r_out_valid;
    logic [7:0]                    r_out_data;

    logic [wlps_pkg::PIU_W-1:0]    w_active;
    logic                          w_scan_end;
    logic [IDX_W-1:0]              w_idx;
    logic [wlps_pkg::WEIGHT_W-1:0] w_weight;
    logic                          w_accept;
    logic                          w_out_free;
    logic [1:0]                    w_fpeer;
    logic                          w_rel_ok;

    wlps_pkg::t_div_req            w_div_req;
    wlps_pkg::t_div_stat           w_div_stat;

    always_comb begin
        w_active   = (r_peers_in_use > wlps_pkg::PIU_W'(NSTORE))
                     ? wlps_pkg::PIU_W'(NSTORE) : r_peers_in_use;
        w_scan_end = (wlps_pkg::PIU_W'(r_idx) >= w_active);
        w_idx      = r_idx[IDX_W-1:0];
        w_weight   = r_weight[2'(w_idx)];
        if (w_weight == '0) begin
            w_weight = wlps_pkg::WEIGHT_W'(1);
        end
        w_accept   = i_s_tvalid && o_s_tready;
        w_out_free = !r_out_valid || i_m_tready;
        w_fpeer    = i_s_tdata[2:1];
        w_rel_ok   = i_s_tdata[3] && ({1'b0, w_fpeer} < 3'(NSTORE));

        w_div_req.start    = (r_state == ST_SCAN) && !w_scan_end && !r_dead[w_idx];
        w_div_req.dividend = {r_use[w_idx], wlps_pkg::PRIO_SHIFT'(0)};
        w_div_req.divisor  = w_weight;
    end

    wlps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_stat  (w_div_stat)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peers_in_use <= wlps_pkg::PIU_W'(4);
            r_rebal_ivl    <= '0;
            for (int i = 0; i < wlps_pkg::ADDR_PEERS; i++) begin
                r_weight[i] <= wlps_pkg::WEIGHT_W'(1);
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wlps_pkg::CFG_PEERS_IN_USE: r_peers_in_use <= i_cfg_wdata[wlps_pkg::PIU_W-1:0];
                wlps_pkg::CFG_REBAL_IVL:    r_rebal_ivl    <= i_cfg_wdata;
                wlps_pkg::CFG_WEIGHT_0:     r_weight[0] <= i_cfg_wdata[wlps_pkg::WEIGHT_W-1:0];
                wlps_pkg::CFG_WEIGHT_1:     r_weight[1] <= i_cfg_wdata[wlps_pkg::WEIGHT_W-1:0];
                wlps_pkg::CFG_WEIGHT_2:     r_weight[2] <= i_cfg_wdata[wlps_pkg::WEIGHT_W-1:0];
                wlps_pkg::CFG_WEIGHT_3:     r_weight[3] <= i_cfg_wdata[wlps_pkg::WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and peer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_dead       <= '0;
            r_sel_cnt    <= '0;
            r_idx        <= '0;
            r_best_valid <= 1'b0;
            r_failed     <= 1'b0;
            r_ok         <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < NSTORE; i++) begin
                r_use[i] <= '0;
            end
        end else begin
            if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_failed     <= i_s_tdata[0];
                        r_ok         <= 1'b0;
                        r_best_idx   <= '0;
                        r_idx        <= '0;
                        r_best_valid <= 1'b0;
                        if (i_s_tuser == wlps_pkg::CMD_REPORT) begin
                            if (w_rel_ok) begin
                                if (r_use[w_fpeer[IDX_W-1:0]] != '0) begin
                                    r_use[w_fpeer[IDX_W-1:0]] <=
                                        r_use[w_fpeer[IDX_W-1:0]] - 1'b1;
                                end
                                r_dead[w_fpeer[IDX_W-1:0]] <= 1'b1;
                            end
                            r_state <= ST_FIN;
                        end else begin
                            if ((r_rebal_ivl != '0) && (r_sel_cnt == r_rebal_ivl)) begin
                                r_dead    <= '0;
                                r_sel_cnt <= wlps_pkg::IVL_W'(1);
                            end else begin
                                r_sel_cnt <= r_sel_cnt + 1'b1;
                            end
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (w_scan_end) begin
                        r_state <= ST_PICK;
                    end else if (r_dead[w_idx]) begin
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (w_div_stat.done) begin
                        // strict compare: ties stay with the lower index
                        if (!r_best_valid || (w_div_stat.quotient < r_best_prio)) begin
                            r_best_valid <= 1'b1;
                            r_best_idx   <= w_idx;
                            r_best_prio  <= w_div_stat.quotient;
                        end
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_SCAN;
                    end
                end
                ST_PICK: begin
                    if (r_best_valid) begin
                        if (r_use[r_best_idx] != {wlps_pkg::USE_W{1'b1}}) begin
                            r_use[r_best_idx] <= r_use[r_best_idx] + 1'b1;
                        end
                        r_ok    <= 1'b1;
                        r_state <= ST_FIN;
                    end else if (!r_failed) begin
                        // all dead: spend the one retry
                        r_failed  <= 1'b1;
                        r_dead    <= '0;
                        r_sel_cnt <= wlps_pkg::IVL_W'(1);
                        r_idx     <= '0;
                        r_state   <= ST_SCAN;
                    end else begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {4'b0000, r_failed,
                                        r_ok ? 2'(r_best_idx) : 2'b00, r_ok};
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
